FILE: design/strs_pkg.sv
// Package: shared constants, codes and control types for the scope task release stack.
`default_nettype none

package strs_pkg;

    localparam int TASK_DEPTH  = 64;
    localparam int SCOPE_DEPTH = 16;

    localparam int ID_W     = 31;
    localparam int DEPTH_W  = 5;
    localparam int FILL_W   = $clog2(TASK_DEPTH + 1);
    localparam int ADDR_W   = $clog2(TASK_DEPTH);
    localparam int SCOPE_W  = $clog2(SCOPE_DEPTH + 1);
    localparam int SIDX_W   = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;

    typedef enum logic [1:0] {
        CMD_OPEN  = 2'd0,
        CMD_CLOSE = 2'd1,
        CMD_REG   = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_RELEASED  = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_FULL      = 3'd4,
        ST_NO_SCOPE  = 3'd5
    } status_t;

    typedef enum logic {
        S_IDLE    = 1'b0,
        S_RELEASE = 1'b1
    } state_t;

    typedef struct packed {
        logic    do_open;
        logic    do_close;
        logic    do_reg;
        logic    do_load;
        logic    do_step;
        logic    out_valid;
        status_t out_status;
        logic    out_last;
        logic    out_rel;
    } ctrl_cmd_t;

    typedef struct packed {
        logic scope_full;
        logic scope_empty;
        logic buf_full;
        logic rel_nonempty;
        logic rd_last;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: design/strs_ctrl.sv
// Controller: command decode and release sequencing state machine.
`default_nettype none

module strs_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         command,
    input  wire strs_pkg::dp_stat_t stat,
    output strs_pkg::ctrl_cmd_t     cmd,
    output logic                    busy
);
    import strs_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg == S_RELEASE);
    assign accept = start && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd_t'(command) == CMD_CLOSE) && !stat.scope_empty
                    && stat.rel_nonempty)
                begin
                    state_next = S_RELEASE;
                end
            end
            S_RELEASE:
            begin
                if (stat.rd_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.out_status = ST_DONE;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.out_valid = 1'b1;
                    cmd.out_last  = 1'b1;
                    case (cmd_t'(command))
                        CMD_OPEN:
                        begin
                            if (stat.scope_full)
                            begin
                                cmd.out_status = ST_OVERFLOW;
                            end
                            else
                            begin
                                cmd.do_open = 1'b1;
                            end
                        end
                        CMD_CLOSE:
                        begin
                            if (stat.scope_empty)
                            begin
                                cmd.out_status = ST_UNDERFLOW;
                            end
                            else
                            begin
                                cmd.do_close = 1'b1;
                                if (stat.rel_nonempty)
                                begin
                                    cmd.do_load   = 1'b1;
                                    cmd.out_valid = 1'b0;
                                    cmd.out_last  = 1'b0;
                                end
                            end
                        end
                        CMD_REG:
                        begin
                            if (stat.scope_empty)
                            begin
                                cmd.out_status = ST_NO_SCOPE;
                            end
                            else if (stat.buf_full)
                            begin
                                cmd.out_status = ST_FULL;
                            end
                            else
                            begin
                                cmd.do_reg = 1'b1;
                            end
                        end
                        default:
                        begin
                            cmd.out_status = ST_DONE;
                        end
                    endcase
                end
            end
            S_RELEASE:
            begin
                cmd.do_step    = 1'b1;
                cmd.out_valid  = 1'b1;
                cmd.out_status = ST_RELEASED;
                cmd.out_last   = stat.rd_last;
                cmd.out_rel    = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: design/strs_datapath.sv
// Datapath: task buffer memory, scope mark stack, fill level and result registers.
`default_nettype none

module strs_datapath
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic [strs_pkg::ID_W-1:0] task_id,
    input  wire logic                      cfg_write,
    input  wire logic                      cfg_data,
    input  wire strs_pkg::ctrl_cmd_t       cmd,
    output strs_pkg::dp_stat_t             stat,
    output logic                           strobe,
    output logic [2:0]                     status,
    output logic [strs_pkg::ID_W-1:0]      released_task,
    output logic                           last,
    output logic [strs_pkg::DEPTH_W-1:0]   depth
);
    import strs_pkg::*;

    logic [ID_W-1:0]    task_mem [TASK_DEPTH];
    logic [FILL_W-1:0]  marks_reg [SCOPE_DEPTH];

    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [SCOPE_W-1:0] open_reg, open_next;
    logic [FILL_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  end_reg, end_next;
    logic               rel_en_reg;
    logic [ID_W-1:0]    rd_data_reg;
    logic               strobe_reg;
    status_t            status_reg;
    logic               last_reg;
    logic               rel_reg;

    logic [SIDX_W-1:0]  top_idx;
    logic [FILL_W-1:0]  mark_raw;
    logic [FILL_W-1:0]  mark_clamp;

    assign top_idx    = SIDX_W'(open_reg - SCOPE_W'(1));
    assign mark_raw   = marks_reg[top_idx];
    assign mark_clamp = (mark_raw > fill_reg) ? fill_reg : mark_raw;

    assign stat.scope_full   = (open_reg == SCOPE_W'(SCOPE_DEPTH));
    assign stat.scope_empty  = (open_reg == '0);
    assign stat.buf_full     = (fill_reg == FILL_W'(TASK_DEPTH));
    assign stat.rel_nonempty = rel_en_reg && (mark_clamp != fill_reg);
    assign stat.rd_last      = ((rd_ptr_reg + FILL_W'(1)) == end_reg);

    always_comb
    begin
        fill_next   = fill_reg;
        open_next   = open_reg;
        rd_ptr_next = rd_ptr_reg;
        end_next    = end_reg;
        if (cmd.do_reg)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        if (cmd.do_open)
        begin
            open_next = open_reg + SCOPE_W'(1);
        end
        if (cmd.do_close)
        begin
            open_next = open_reg - SCOPE_W'(1);
            fill_next = mark_clamp;
        end
        if (cmd.do_load)
        begin
            rd_ptr_next = mark_clamp;
            end_next    = fill_reg;
        end
        if (cmd.do_step)
        begin
            rd_ptr_next = rd_ptr_reg + FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            open_reg   <= '0;
            rel_en_reg <= 1'b1;
            strobe_reg <= 1'b0;
        end
        else
        begin
            fill_reg   <= fill_next;
            open_reg   <= open_next;
            strobe_reg <= cmd.out_valid;
            if (cfg_write)
            begin
                rel_en_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg <= rd_ptr_next;
        end_reg    <= end_next;
        status_reg <= cmd.out_status;
        last_reg   <= cmd.out_last;
        rel_reg    <= cmd.out_rel;
        if (cmd.do_open)
        begin
            marks_reg[SIDX_W'(open_reg)] <= fill_reg;
        end
    end

    // task buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.do_reg)
        begin
            task_mem[fill_reg[ADDR_W-1:0]] <= task_id;
        end
        rd_data_reg <= task_mem[rd_ptr_reg[ADDR_W-1:0]];
    end

    assign strobe        = strobe_reg;
    assign status        = status_reg;
    assign last          = last_reg;
    assign released_task = rel_reg ? rd_data_reg : '0;
    assign depth         = DEPTH_W'(open_reg);

endmodule

`default_nettype wire

FILE: design/scope_task_release_stack.sv
// Top level: scope task release stack, controller plus datapath.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  command   | start / busy         | command[1:0], task_id[30:0]
//  result    | strobe (no backpr.)  | status[2:0], released_task[30:0],
//            |                      | last, depth[4:0]
//  config    | cfg_write            | cfg_data (release_enable)
//
// Open, register, plain close and error transactions: result registered in the cycle
// after acceptance; busy stays low, so a transaction may be accepted every cycle.
// Close with release: busy during the release state, N results one per cycle, each
// registered from a release-state read, paced by the single task buffer read port.
// Reset: no scopes open, buffer empty, release enabled; no clearing pass.
// The receiver cannot stall; results are never held.
`default_nettype none

module scope_task_release_stack
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [1:0]                     command,
    input  wire logic [strs_pkg::ID_W-1:0]      task_id,
    input  wire logic                           cfg_write,
    input  wire logic                           cfg_data,
    output logic                                strobe,
    output logic [2:0]                          status,
    output logic [strs_pkg::ID_W-1:0]           released_task,
    output logic                                last,
    output logic [strs_pkg::DEPTH_W-1:0]        depth
);
    import strs_pkg::*;

    ctrl_cmd_t ctrl_cmd;
    dp_stat_t  dp_stat;

    strs_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (command),
        .stat    (dp_stat),
        .cmd     (ctrl_cmd),
        .busy    (busy)
    );

    strs_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .task_id       (task_id),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .cmd           (ctrl_cmd),
        .stat          (dp_stat),
        .strobe        (strobe),
        .status        (status),
        .released_task (released_task),
        .last          (last),
        .depth         (depth)
    );

endmodule

`default_nettype wire

FILE: design/strs_checker.sv
// Checker: port-level assertions for the scope task release stack, with bind.
`default_nettype none

module strs_checker
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      busy,
    input  wire logic [1:0]                command,
    input  wire logic                      strobe,
    input  wire logic [2:0]                status,
    input  wire logic [strs_pkg::ID_W-1:0] released_task,
    input  wire logic                      last
);
    import strs_pkg::*;

    // non-close transactions answer on the next cycle with a single result
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (command != CMD_CLOSE)) |=> (strobe && last))
        else $error("single-result transaction gave no result");

    // every release cycle yields a result
    a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> strobe)
        else $error("release cycle without result");

    // release stream is unbroken until last
    a_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> (strobe && (status == ST_RELEASED)))
        else $error("release stream broken");

    // non-release results are single, with a zero id
    a_plain: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && (status != ST_RELEASED)) |-> (last && (released_task == '0)))
        else $error("malformed non-release result");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((status == ST_DONE) || (status == ST_RELEASED)
                    || (status == ST_OVERFLOW) || (status == ST_UNDERFLOW)
                    || (status == ST_FULL) || (status == ST_NO_SCOPE)))
        else $error("status code out of range");

endmodule

bind scope_task_release_stack strs_checker u_strs_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .strobe        (strobe),
    .status        (status),
    .released_task (released_task),
    .last          (last)
);

`default_nettype wire
